// ===== hdl/hfq_pkg.sv =====
// ----------------------------------------------------------------------------
// hfq_pkg: shared types, codes and helpers for the heading fix qualifier
// Holds the transaction, result, state and register types, the opcode and
// reason codes, and the small time-check functions.
// ----------------------------------------------------------------------------
package hfq_pkg;

    localparam int TICK_W = 32;

    // Highest receiver status the minimum-status register may ask for
    localparam logic [1:0] STATUS_CEILING = 2'd2;

    typedef enum logic [1:0] {
        OP_STATUS  = 2'd0,
        OP_HEADING = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CHECK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RSN_OK         = 3'd0,
        RSN_STATUS_NEG = 3'd1,
        RSN_STATUS_LOW = 3'd2,
        RSN_NONE       = 3'd3,
        RSN_INVALID    = 3'd4,
        RSN_STALE      = 3'd5,
        RSN_HOLDOFF    = 3'd6
    } reason_t;

    typedef enum logic [1:0] {
        CFG_MIN_STATUS = 2'd0,
        CFG_HOLDOFF    = 2'd1,
        CFG_MAX_AGE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t                opcode;
        logic signed [3:0]  gnss_status;
        logic [TICK_W-1:0]  stamp_time;
        logic               stamp_ok;
        logic [TICK_W-1:0]  now_time;
        logic               now_ok;
        logic signed [15:0] yaw_angle;
        logic [15:0]        yaw_variance;
        logic               heading_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]        good_status;
        logic [TICK_W-1:0] holdoff;
        logic [TICK_W-1:0] max_age;
    } cfg_t;

    typedef struct packed {
        logic signed [3:0]  last_status;
        logic [TICK_W-1:0]  holdoff_end;
        logic               have_heading;
        logic signed [15:0] kept_yaw;
        logic [15:0]        kept_variance;
        logic [TICK_W-1:0]  kept_stamp;
    } state_t;

    typedef struct packed {
        logic               usable;
        reason_t            reason;
        logic signed [15:0] out_yaw;
        logic [15:0]        out_variance;
        logic [TICK_W-1:0]  out_stamp;
    } result_t;

    // Clamp the minimum-status register to the ceiling
    function automatic logic [1:0] eff_min_status(input logic [1:0] good_status);
        return (good_status > STATUS_CEILING) ? STATUS_CEILING : good_status;
    endfunction

    // Status strictly below the effective minimum (signed compare)
    function automatic logic status_below(input logic signed [3:0] status,
                                          input logic [1:0] good_status);
        logic signed [3:0] m;
        m = $signed({2'b00, eff_min_status(good_status)});
        return status < m;
    endfunction

    // Absolute gap between two times within the age limit; zero limit passes
    function automatic logic age_ok(input logic [TICK_W-1:0] now,
                                    input logic [TICK_W-1:0] stamp,
                                    input logic [TICK_W-1:0] max_age);
        logic [TICK_W-1:0] gap;
        gap = (now >= stamp) ? (now - stamp) : (stamp - now);
        return (max_age == '0) || (gap <= max_age);
    endfunction

endpackage

// ===== hdl/heading_fix_qualifier.sv =====
// ----------------------------------------------------------------------------
// heading_fix_qualifier: satellite heading fix qualifier
// Flow: an accepted transaction is captured in the input register, qualified
//   combinationally, and committed to the state as it leaves that register.
// Throughput: one transaction per cycle unless a result waits on a full result
//   register; the input and result registers form a two-stage pipeline.
// Reset: asynchronous active low; registers return to their reset values
//   (minimum status 1, no hold-off, no age limit, status outage, no heading).
// ----------------------------------------------------------------------------
module heading_fix_qualifier (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    // input transaction channel
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         opcode,
    input  logic signed [3:0]  gnss_status,
    input  logic [31:0]        stamp_time,
    input  logic               stamp_ok,
    input  logic [31:0]        now_time,
    input  logic               now_ok,
    input  logic signed [15:0] yaw_angle,
    input  logic [15:0]        yaw_variance,
    input  logic               heading_ok,
    // result transaction channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic               usable,
    output logic [2:0]         reason_code,
    output logic signed [15:0] out_yaw,
    output logic [15:0]        out_variance,
    output logic [31:0]        out_stamp
);
    import hfq_pkg::*;

    // Stage one: registered input transaction
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    item_t   item_in;

    // Stage two: registered result
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;

    cfg_t    cfg;
    state_t  state;
    result_t eval_result;

    logic    s1_emits;
    logic    res_free;
    logic    s1_fire;
    logic    item_fire;

    assign item_in.opcode       = op_t'(opcode);
    assign item_in.gnss_status  = gnss_status;
    assign item_in.stamp_time   = stamp_time;
    assign item_in.stamp_ok     = stamp_ok;
    assign item_in.now_time     = now_time;
    assign item_in.now_ok       = now_ok;
    assign item_in.yaw_angle    = yaw_angle;
    assign item_in.yaw_variance = yaw_variance;
    assign item_in.heading_ok   = heading_ok;

    // Only queries and sample checks produce a result; status and heading
    // updates retire without touching the result register.
    assign s1_emits = (s1_item_reg.opcode == OP_QUERY) ||
                      (s1_item_reg.opcode == OP_CHECK);

    // Result register can load when empty or being drained this cycle
    assign res_free  = !res_valid_reg || result_ready;
    assign s1_fire   = s1_valid_reg && (!s1_emits || res_free);
    assign item_ready = !s1_valid_reg || s1_fire;
    assign item_fire  = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_fire && s1_emits)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    // Hold configuration and qualifier state; commit updates as stage one retires
    hfq_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .commit    (s1_fire),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .state     (state)
    );

    // Qualify against the state as it stands before this transaction commits
    hfq_eval u_eval (
        .item   (s1_item_reg),
        .cfg    (cfg),
        .state  (state),
        .result (eval_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (item_fire)
            s1_item_reg <= item_in;
        if (s1_fire && s1_emits)
            res_reg <= eval_result;
    end

    assign result_valid = res_valid_reg;
    assign usable       = res_reg.usable;
    assign reason_code  = res_reg.reason;
    assign out_yaw      = res_reg.out_yaw;
    assign out_variance = res_reg.out_variance;
    assign out_stamp    = res_reg.out_stamp;

endmodule

// ===== hdl/hfq_state.sv =====
// ----------------------------------------------------------------------------
// hfq_state: configuration and qualifier state registers
// Takes register writes, and applies status and heading transactions to the
// stored status, hold-off end and kept heading when they commit.
// ----------------------------------------------------------------------------
module hfq_state (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    input  logic           commit,
    input  hfq_pkg::item_t item,
    output hfq_pkg::cfg_t  cfg,
    output hfq_pkg::state_t state
);
    import hfq_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    state_t state_reg;
    state_t state_next;

    logic [TICK_W:0] end_sum;

    assign end_sum = {1'b0, item.stamp_time} + {1'b0, cfg_reg.holdoff};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_STATUS: cfg_next.good_status = cfg_wdata[1:0];
                CFG_HOLDOFF:    cfg_next.holdoff     = cfg_wdata;
                CFG_MAX_AGE:    cfg_next.max_age     = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (commit)
        begin
            case (item.opcode)
                OP_STATUS:
                begin
                    state_next.last_status = item.gnss_status;
                    if (item.gnss_status < 0)
                        state_next.have_heading = 1'b0;
                    else if (cfg_reg.holdoff != '0 && item.stamp_ok &&
                             status_below(state_reg.last_status, cfg_reg.good_status) &&
                             !status_below(item.gnss_status, cfg_reg.good_status))
                        state_next.holdoff_end = end_sum[TICK_W] ? '1 : end_sum[TICK_W-1:0];
                end
                OP_HEADING:
                begin
                    if (item.heading_ok && item.yaw_variance != '0 && item.stamp_ok)
                    begin
                        state_next.have_heading  = 1'b1;
                        state_next.kept_yaw      = item.yaw_angle;
                        state_next.kept_variance = item.yaw_variance;
                        state_next.kept_stamp    = item.stamp_time;
                    end
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_status <= 2'd1;
            cfg_reg.holdoff     <= '0;
            cfg_reg.max_age     <= '0;
            state_reg.last_status   <= -4'sd8;
            state_reg.holdoff_end   <= '0;
            state_reg.have_heading  <= 1'b0;
            state_reg.kept_yaw      <= '0;
            state_reg.kept_variance <= '0;
            state_reg.kept_stamp    <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

    assign cfg   = cfg_reg;
    assign state = state_reg;

endmodule

// ===== hdl/hfq_eval.sv =====
// ----------------------------------------------------------------------------
// hfq_eval: heading qualification checks
// Runs the status, presence, validity, age and hold-off checks for a query
// or sample-check transaction; the first failing check sets the reason.
// ----------------------------------------------------------------------------
module hfq_eval (
    input  hfq_pkg::item_t   item,
    input  hfq_pkg::cfg_t    cfg,
    input  hfq_pkg::state_t  state,
    output hfq_pkg::result_t result
);
    import hfq_pkg::*;

    reason_t           reason;
    logic              give_stored;
    logic [TICK_W-1:0] ref_stamp;
    logic              held;

    // Stored query ages the kept stamp, sample check ages the supplied one
    assign ref_stamp = (item.opcode == OP_QUERY) ? state.kept_stamp : item.stamp_time;
    assign held = (cfg.holdoff != '0) &&
                  ((item.now_time < state.holdoff_end) || (ref_stamp < state.holdoff_end));

    always_comb
    begin
        give_stored = 1'b0;
        if (state.last_status < 0)
            reason = RSN_STATUS_NEG;
        else if (status_below(state.last_status, cfg.good_status))
            reason = RSN_STATUS_LOW;
        else if (item.opcode == OP_QUERY)
        begin
            if (!state.have_heading)
                reason = RSN_NONE;
            else if (state.kept_variance == '0)
                reason = RSN_INVALID;
            else if (!item.now_ok || !age_ok(item.now_time, ref_stamp, cfg.max_age))
                reason = RSN_STALE;
            else if (held)
                reason = RSN_HOLDOFF;
            else
            begin
                reason      = RSN_OK;
                give_stored = 1'b1;
            end
        end
        else
        begin
            if (!item.heading_ok || item.yaw_variance == '0 || !item.stamp_ok ||
                !item.now_ok)
                reason = RSN_INVALID;
            else if (!age_ok(item.now_time, ref_stamp, cfg.max_age))
                reason = RSN_STALE;
            else if (held)
                reason = RSN_HOLDOFF;
            else
                reason = RSN_OK;
        end
    end

    always_comb
    begin
        result.usable       = (reason == RSN_OK);
        result.reason       = reason;
        result.out_yaw      = give_stored ? state.kept_yaw      : '0;
        result.out_variance = give_stored ? state.kept_variance : '0;
        result.out_stamp    = give_stored ? state.kept_stamp    : '0;
    end

endmodule

// ===== verif/fix_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fix_verdict_checker: verdict predictor and comparator for the qualifier
// Watches the register write port and both transaction channels, keeps its
// own copy of the qualifier state, predicts each verdict and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module fix_verdict_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               item_valid,
    input  logic               item_ready,
    input  hfq_pkg::item_t     item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic               usable,
    input  logic [2:0]         reason_code,
    input  logic signed [15:0] out_yaw,
    input  logic [15:0]        out_variance,
    input  logic [31:0]        out_stamp,
    output int                 fail_count,
    output int                 open_count,
    output int                 checked_count
);
    import hfq_pkg::*;

    // register copies
    logic [1:0]         min_status_r;
    logic [31:0]        holdoff_r;
    logic [31:0]        max_age_r;

    // qualifier state
    logic signed [3:0]  status_r;
    logic [31:0]        holdoff_end_r;
    logic               have_fix_r;
    logic signed [15:0] fix_yaw_r;
    logic [15:0]        fix_spread_r;
    logic [31:0]        fix_stamp_r;

    result_t            verdicts_due[$];
    int                 fails;
    int                 checked;

    function automatic int status_floor();
        return (min_status_r > STATUS_CEILING) ? int'(STATUS_CEILING) : int'(min_status_r);
    endfunction

    function automatic logic fresh(input logic [31:0] now, input logic [31:0] stamp);
        logic [31:0] gap;
        gap = (now >= stamp) ? now - stamp : stamp - now;
        return (max_age_r == '0) || (gap <= max_age_r);
    endfunction

    function automatic logic held_off(input logic [31:0] now, input logic [31:0] stamp);
        return (holdoff_r != '0) && ((now < holdoff_end_r) || (stamp < holdoff_end_r));
    endfunction

    // Advance the state by one transaction and queue the verdict it causes
    task automatic qualify(input item_t it);
        result_t     v;
        logic [32:0] end_sum;
        v = '0;
        v.reason = RSN_OK;
        case (it.opcode)
            OP_STATUS:
            begin
                if (it.gnss_status[3])
                    have_fix_r = 1'b0;
                else if (holdoff_r != '0 && it.stamp_ok
                         && int'($signed(status_r)) < status_floor()
                         && int'($signed(it.gnss_status)) >= status_floor())
                begin
                    end_sum = {1'b0, it.stamp_time} + {1'b0, holdoff_r};
                    holdoff_end_r = end_sum[32] ? '1 : end_sum[31:0];
                end
                status_r = it.gnss_status;
            end
            OP_HEADING:
            begin
                if (it.heading_ok && it.yaw_variance != '0 && it.stamp_ok)
                begin
                    have_fix_r   = 1'b1;
                    fix_yaw_r    = it.yaw_angle;
                    fix_spread_r = it.yaw_variance;
                    fix_stamp_r  = it.stamp_time;
                end
            end
            default:
            begin
                if (status_r[3])
                    v.reason = RSN_STATUS_NEG;
                else if (int'($signed(status_r)) < status_floor())
                    v.reason = RSN_STATUS_LOW;
                else if (it.opcode == OP_QUERY)
                begin
                    if (!have_fix_r)
                        v.reason = RSN_NONE;
                    else if (fix_spread_r == '0)
                        v.reason = RSN_INVALID;
                    else if (!it.now_ok || !fresh(it.now_time, fix_stamp_r))
                        v.reason = RSN_STALE;
                    else if (held_off(it.now_time, fix_stamp_r))
                        v.reason = RSN_HOLDOFF;
                    else
                    begin
                        v.out_yaw      = fix_yaw_r;
                        v.out_variance = fix_spread_r;
                        v.out_stamp    = fix_stamp_r;
                    end
                end
                else
                begin
                    if (!it.heading_ok || it.yaw_variance == '0 || !it.stamp_ok || !it.now_ok)
                        v.reason = RSN_INVALID;
                    else if (!fresh(it.now_time, it.stamp_time))
                        v.reason = RSN_STALE;
                    else if (held_off(it.now_time, it.stamp_time))
                        v.reason = RSN_HOLDOFF;
                end
                v.usable = (v.reason == RSN_OK);
                verdicts_due.push_back(v);
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (verdicts_due.size() == 0)
        begin
            $display("%0t: result with nothing pending, expected none actual reason %0d",
                     $time, reason_code);
            fails++;
        end
        else
        begin
            want = verdicts_due.pop_front();
            compare_field("usable", 32'(want.usable), 32'(usable));
            compare_field("reason_code", 32'(want.reason), 32'(reason_code));
            compare_field("out_yaw", 32'(want.out_yaw), 32'(out_yaw));
            compare_field("out_variance", 32'(want.out_variance), 32'(out_variance));
            compare_field("out_stamp", want.out_stamp, out_stamp);
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_status_r  = 2'd1;
            holdoff_r     = '0;
            max_age_r     = '0;
            status_r      = -4'sd8;
            holdoff_end_r = '0;
            have_fix_r    = 1'b0;
            fix_yaw_r     = '0;
            fix_spread_r  = '0;
            fix_stamp_r   = '0;
            verdicts_due.delete();
            fails         = 0;
            checked       = 0;
            fail_count    <= 0;
            open_count    <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_STATUS: min_status_r = cfg_wdata[1:0];
                    CFG_HOLDOFF:    holdoff_r    = cfg_wdata;
                    CFG_MAX_AGE:    max_age_r    = cfg_wdata;
                    default:        ;
                endcase
            end
            if (item_valid && item_ready)
                qualify(item);
            fail_count    <= fails;
            open_count    <= verdicts_due.size();
            checked_count <= checked;
        end
    end

endmodule

// ===== verif/tb_heading_fix_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_fix_qualifier: stimulus and verdict for the heading qualifier
// Runs a short directed sequence through every opcode and reason code, then
// random transactions under several register settings with random idle
// bursts on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_heading_fix_qualifier;
    import hfq_pkg::*;

    localparam int         NUM_SETTINGS      = 8;
    localparam int         ITEMS_PER_SETTING = 125;
    localparam int         CYCLE_LIMIT       = 400000;
    // register index that the block decodes to nothing
    localparam logic [1:0] CFG_SPARE         = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               item_valid;
    logic               item_ready;
    item_t              tx;
    logic               result_valid;
    logic               result_ready;
    logic               usable;
    logic [2:0]         reason_code;
    logic signed [15:0] out_yaw;
    logic [15:0]        out_variance;
    logic [31:0]        out_stamp;

    int                 fail_count;
    int                 open_count;
    int                 checked_count;
    int                 items_sent;
    int                 cycles = 0;
    // idle bursts on the sender and on the receiver side
    bit                 send_gaps;
    bit                 stall_gaps;
    // running time base so that random stamps and queries land near each other
    logic [31:0]        tick_base;

    always #5 clk = ~clk;

    heading_fix_qualifier u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (tx.opcode),
        .gnss_status  (tx.gnss_status),
        .stamp_time   (tx.stamp_time),
        .stamp_ok     (tx.stamp_ok),
        .now_time     (tx.now_time),
        .now_ok       (tx.now_ok),
        .yaw_angle    (tx.yaw_angle),
        .yaw_variance (tx.yaw_variance),
        .heading_ok   (tx.heading_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .usable       (usable),
        .reason_code  (reason_code),
        .out_yaw      (out_yaw),
        .out_variance (out_variance),
        .out_stamp    (out_stamp)
    );

    fix_verdict_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (tx),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .usable        (usable),
        .reason_code   (reason_code),
        .out_yaw       (out_yaw),
        .out_variance  (out_variance),
        .out_stamp     (out_stamp),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .checked_count (checked_count)
    );

    // Build one transaction from plain values
    function automatic item_t mk(input op_t op, input int status,
                                 input logic [31:0] stamp, input bit sok,
                                 input logic [31:0] now, input bit nok,
                                 input int yaw, input int spread, input bit hok);
        item_t it;
        it.opcode       = op;
        it.gnss_status  = 4'(status);
        it.stamp_time   = stamp;
        it.stamp_ok     = sok;
        it.now_time     = now;
        it.now_ok       = nok;
        it.yaw_angle    = 16'(yaw);
        it.yaw_variance = 16'(spread);
        it.heading_ok   = hok;
        return it;
    endfunction

    // Mostly well-formed traffic around the time base, with a share of noise:
    // outages, invalid flags, zero variance and times anywhere in the range.
    function automatic item_t random_fix();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.opcode = OP_STATUS;
        else if (pick < 50)
            it.opcode = OP_HEADING;
        else if (pick < 80)
            it.opcode = OP_QUERY;
        else
            it.opcode = OP_CHECK;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            it.gnss_status = 4'($urandom_range(8, 15));
        else if (pick < 20)
            it.gnss_status = 4'($urandom_range(4, 7));
        else
            it.gnss_status = 4'($urandom_range(0, 3));
        it.stamp_time   = ($urandom_range(0, 19) == 0) ? $urandom
                                                       : tick_base - $urandom_range(0, 250);
        it.now_time     = ($urandom_range(0, 19) == 0) ? $urandom
                                                       : tick_base + $urandom_range(0, 250);
        it.stamp_ok     = ($urandom_range(0, 15) != 0);
        it.now_ok       = ($urandom_range(0, 15) != 0);
        it.heading_ok   = ($urandom_range(0, 15) != 0);
        it.yaw_angle    = 16'($urandom);
        it.yaw_variance = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        return it;
    endfunction

    // Offer one transaction, maybe after an idle burst, and hold it until taken;
    // look at ready mid-cycle, where it is settled for the coming edge
    task automatic send(input item_t it);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid <= 1'b1;
        tx         <= it;
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Drop valid, drain every pending verdict, then let the pipeline settle
    // since status and heading updates leave nothing behind to wait for
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all registers on back-to-back cycles; call only while idle
    task automatic write_regs(input logic [31:0] min_v, input logic [31:0] hold_v,
                              input logic [31:0] age_v, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_STATUS;
        cfg_wdata <= min_v;
        @(posedge clk);
        cfg_index <= CFG_HOLDOFF;
        cfg_wdata <= hold_v;
        @(posedge clk);
        cfg_index <= CFG_MAX_AGE;
        cfg_wdata <= age_v;
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= '1;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Receiver side: random stall bursts while enabled, otherwise always ready
    initial
    begin
        result_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_gaps && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: a hung handshake or a missing verdict ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d verdicts outstanding",
                     cycles, open_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_MIN_STATUS;
        cfg_wdata  <= '0;
        item_valid <= 1'b0;
        tx         <= '0;
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
        tick_base  = 32'd2000;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset register values: outage at reset, low
        // status, no heading, rejected samples, stored extremes, invalid now
        send(mk(OP_QUERY,    0, 32'd0,        1, 32'd0,    1, 0,      0,     1));
        send(mk(OP_CHECK,    0, 32'd10,       1, 32'd10,   1, 100,    5,     1));
        send(mk(OP_STATUS,   0, 32'd50,       1, 32'd0,    0, 0,      0,     0));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd60,   1, 0,      0,     0));
        send(mk(OP_STATUS,   7, 32'd60,       1, 32'd0,    0, 0,      0,     0));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd70,   1, 0,      0,     0));
        send(mk(OP_HEADING,  0, 32'd80,       1, 32'd0,    0, -32768, 0,     1));
        send(mk(OP_HEADING,  0, 32'd80,       1, 32'd0,    0, 5,      3,     0));
        send(mk(OP_HEADING,  0, 32'd80,       0, 32'd0,    0, 5,      3,     1));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd90,   1, 0,      0,     0));
        send(mk(OP_HEADING,  0, 32'hFFFFFFFF, 1, 32'd0,    0, 32767,  65535, 1));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd100,  0, 0,      0,     0));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd0,    1, 0,      0,     0));
        send(mk(OP_CHECK,    0, 32'd100,      1, 32'd100,  0, 7,      7,     1));
        send(mk(OP_CHECK,    0, 32'd100,      1, 32'd100,  1, 7,      0,     1));
        send(mk(OP_CHECK,    0, 32'd100,      1, 32'd100,  1, -7,     7,     1));
        // Outage clears the heading; a heading stored during it stays blocked
        send(mk(OP_STATUS,  -1, 32'd110,      1, 32'd0,    0, 0,      0,     0));
        send(mk(OP_HEADING,  0, 32'd1000,     1, 32'd0,    0, -1234,  9,     1));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd1000, 1, 0,      0,     0));
        wait_idle();

        // Minimum status 3 acts as 2; a full-range hold-off saturates its end
        write_regs(32'd3, '1, 32'd10, 1'b0);
        send(mk(OP_STATUS,   2, 32'd5,        1, 32'd0,    0, 0,      0,     0));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd1005, 1, 0,      0,     0));
        send(mk(OP_CHECK,    0, 32'd2000,     1, 32'd1000, 1, 1,      1,     1));
        // Status recorded without a valid stamp, then below the minimum
        send(mk(OP_STATUS,   1, 32'd9,        0, 32'd0,    0, 0,      0,     0));
        send(mk(OP_QUERY,    0, 32'd0,        0, 32'd1010, 1, 0,      0,     0));
        wait_idle();

        // Random part: one block of transactions per register setting
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            send_gaps  = (p != 2) && (p != NUM_SETTINGS - 1);
            stall_gaps = send_gaps;
            case (p)
                0: write_regs(32'd1, 32'd0, 32'd0, 1'b0);
                1: write_regs(32'd0, 32'd25, 32'd300, 1'b0);
                2: write_regs(32'd2, 32'd80, 32'd150, 1'b0);
                3: write_regs(32'd3, '1, '1, 1'b0);
                4: write_regs(32'd1, 32'd1, 32'd1, 1'b1);
                5:
                begin
                    // junk above the two status bits; run the clock near wrap
                    tick_base = 32'hFFFF_FF00;
                    write_regs(32'hFFFF_FFFE, 32'd60, 32'd0, 1'b0);
                end
                6: write_regs($urandom_range(0, 3), $urandom_range(1, 200),
                              $urandom_range(50, 400), 1'b0);
                default: write_regs(32'd1, 32'd40, 32'd250, 1'b0);
            endcase
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                tick_base += $urandom_range(0, 12);
                send(random_fix());
            end
            wait_idle();
        end

        $display("Covered %0d transactions: directed opcode and reason cases, then random",
                 items_sent);
        $display("traffic over %0d register settings; %0d verdicts compared.",
                 NUM_SETTINGS, checked_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
